@@ sv/deadline_timer_table_core_assert.svh @@
// assertion macros used by the timer table controller
`ifndef DEADLINE_TIMER_TABLE_CORE_ASSERT_SVH
`define DEADLINE_TIMER_TABLE_CORE_ASSERT_SVH
// property that must hold on every clock edge outside reset
`define DTT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// implication whose consequent is checked in the cycle after the condition
`define DTT_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);
`endif

@@ sv/dtt_pkg.sv @@
// shared types and constants for the deadline timer table
`default_nettype none
package dtt_pkg;
  localparam int Entries = 32;
  localparam int IdxW = $clog2(Entries);

  typedef enum logic [1:0] {
    ACT_TICK   = 2'd0,
    ACT_ADD    = 2'd1,
    ACT_DELETE = 2'd2,
    ACT_EXPIRE = 2'd3
  } action_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] conn_id;
    logic [15:0] delay_ms;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] expired_conn;
    logic        have_next;
    logic [15:0] next_remaining_ms;
    logic        status;
    logic        last;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic do_tick;
    logic do_add;
    logic do_delete;
    logic scan_start;
    logic scan_step;
    logic free_best;
    logic purge_dead;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;
    logic best_found;
    logic best_due;
    logic full;
  } dp_stat_t;
endpackage
`default_nettype wire

@@ sv/deadline_timer_table_core.sv @@
// deadline timer table: top level joining controller and datapath
// an action takes an exec step, a scan of the table, a decide step and a final
// step that forms the status result; each expired report adds a rescan of the
// table, as the earliest deadline is searched one slot a cycle
// one action at a time: the next is taken only after the previous is finished
// reset: synchronous rst clears the clock, all entry flags and the controller
`default_nettype none
module deadline_timer_table_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire dtt_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output dtt_pkg::out_item_t      out_data
);
  import dtt_pkg::*;

  in_item_t    item;
  dp_cmd_t     cmd;
  dp_stat_t    stat;
  logic [15:0] best_conn;
  logic [15:0] best_remaining;

  dtt_control u_control (
    .clk, .rst, .in_valid, .in_stall, .in_data, .item, .cmd, .stat,
    .best_conn, .best_remaining, .out_valid, .out_stall, .out_data
  );

  dtt_datapath u_datapath (
    .clk, .rst, .item, .cmd, .stat, .best_conn, .best_remaining
  );
endmodule
`default_nettype wire

@@ sv/dtt_datapath.sv @@
// timer table storage, slot search and earliest deadline scan
`default_nettype none
module dtt_datapath (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire dtt_pkg::in_item_t item,
  input  wire dtt_pkg::dp_cmd_t  cmd,
  output dtt_pkg::dp_stat_t      stat,
  output logic [15:0]            best_conn,
  output logic [15:0]            best_remaining
);
  import dtt_pkg::*;

  logic [31:0]       now_ms;
  logic [31:0]       deadline_mem [Entries];
  logic [15:0]       conn_mem [Entries];
  logic [Entries-1:0] valid;
  logic [Entries-1:0] dead;
  logic [Entries-1:0] newest;

  logic [IdxW:0]     scan_idx;
  logic              best_found;
  logic [IdxW-1:0]   best_idx;
  logic signed [31:0] best_left;
  logic [15:0]       best_conn_r;

  logic [IdxW-1:0]   free_idx;
  logic              free_found;
  logic [IdxW-1:0]   del_idx;
  logic              del_found;
  logic [IdxW-1:0]   cur;
  logic signed [31:0] cur_left;
  logic              cur_live;

  always_comb begin
    free_found = 1'b0;
    free_idx = '0;
    for (int i = Entries - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        free_found = 1'b1;
        free_idx = IdxW'(i);
      end
    end
  end

  always_comb begin
    del_found = 1'b0;
    del_idx = '0;
    for (int i = Entries - 1; i >= 0; i--) begin
      if (valid[i] && newest[i] && conn_mem[i] == item.conn_id) begin
        del_found = 1'b1;
        del_idx = IdxW'(i);
      end
    end
  end

  assign cur = scan_idx[IdxW-1:0];
  assign cur_live = valid[cur] && !dead[cur];
  assign cur_left = $signed(deadline_mem[cur] - now_ms);

  always_ff @(posedge clk) begin
    if (rst) begin
      now_ms <= '0;
      valid <= '0;
      dead <= '0;
      newest <= '0;
      scan_idx <= '0;
      best_found <= 1'b0;
    end else begin
      if (cmd.do_tick) begin
        now_ms <= now_ms + 32'd1;
      end
      if (cmd.do_add && free_found) begin
        for (int i = 0; i < Entries; i++) begin
          if (valid[i] && conn_mem[i] == item.conn_id) begin
            newest[i] <= 1'b0;
          end
        end
        deadline_mem[free_idx] <= now_ms + {16'd0, item.delay_ms};
        conn_mem[free_idx] <= item.conn_id;
        valid[free_idx] <= 1'b1;
        dead[free_idx] <= 1'b0;
        newest[free_idx] <= 1'b1;
      end
      if (cmd.do_delete && del_found) begin
        dead[del_idx] <= 1'b1;
      end
      if (cmd.purge_dead) begin
        valid <= valid & ~dead;
        newest <= newest & ~dead;
        dead <= '0;
      end
      if (cmd.free_best) begin
        valid[best_idx] <= 1'b0;
        dead[best_idx] <= 1'b0;
        newest[best_idx] <= 1'b0;
      end
      if (cmd.scan_start) begin
        scan_idx <= '0;
        best_found <= 1'b0;
      end else if (cmd.scan_step && scan_idx != (IdxW+1)'(Entries)) begin
        // strict compare keeps the lower slot on equal deadlines
        if (cur_live && (!best_found || cur_left < best_left)) begin
          best_found <= 1'b1;
          best_idx <= cur;
          best_left <= cur_left;
          best_conn_r <= conn_mem[cur];
        end
        scan_idx <= scan_idx + 1'b1;
      end
    end
  end

  assign stat.scan_done = (scan_idx == (IdxW+1)'(Entries));
  assign stat.best_found = best_found;
  assign stat.best_due = best_left <= 32'sd0;
  assign stat.full = !free_found;
  assign best_conn = best_conn_r;
  always_comb begin
    if (best_left <= 32'sd0) begin
      best_remaining = '0;
    end else if (best_left > 32'sd65535) begin
      best_remaining = 16'hFFFF;
    end else begin
      best_remaining = best_left[15:0];
    end
  end
endmodule
`default_nettype wire

@@ sv/dtt_control.sv @@
// sequencer for actions, expiry loop and result transfers
`default_nettype none
module dtt_control (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire dtt_pkg::in_item_t  in_data,
  output dtt_pkg::in_item_t       item,
  output dtt_pkg::dp_cmd_t        cmd,
  input  wire dtt_pkg::dp_stat_t  stat,
  input  wire logic [15:0]        best_conn,
  input  wire logic [15:0]        best_remaining,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output dtt_pkg::out_item_t      out_data
);
  import dtt_pkg::*;
  `include "deadline_timer_table_core_assert.svh"

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_SCAN, S_DECIDE, S_FINAL, S_WAIT
  } state_t;

  state_t state;
  logic   refused;
  logic   expiring;
  logic   in_xfer;
  logic   out_free;

  assign in_stall = (state != S_IDLE);
  assign in_xfer = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    cmd = '0;
    case (state)
      S_EXEC: begin
        cmd.do_tick = (item.action == ACT_TICK);
        cmd.do_add = (item.action == ACT_ADD);
        cmd.do_delete = (item.action == ACT_DELETE);
        cmd.scan_start = 1'b1;
      end
      S_SCAN: cmd.scan_step = 1'b1;
      S_DECIDE: begin
        if (expiring && stat.best_found && stat.best_due && out_free) begin
          cmd.free_best = 1'b1;
          cmd.scan_start = 1'b1;
        end
      end
      // dead entries were skipped by the scan, so they can go once it is over
      S_FINAL: cmd.purge_dead = 1'b1;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      refused <= 1'b0;
      expiring <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            item <= in_data;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          refused <= (item.action == ACT_ADD) && stat.full;
          expiring <= (item.action == ACT_EXPIRE);
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (stat.scan_done) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (expiring && stat.best_found && stat.best_due) begin
            if (out_free) begin
              out_valid <= 1'b1;
              out_data <= '{kind: 1'b1, expired_conn: best_conn, have_next: 1'b0,
                            next_remaining_ms: 16'd0, status: 1'b0, last: 1'b0};
              state <= S_SCAN;
            end
          end else begin
            state <= S_FINAL;
          end
        end
        S_FINAL: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_data <= '{kind: 1'b0, expired_conn: 16'd0,
                          have_next: stat.best_found,
                          next_remaining_ms: stat.best_found ? best_remaining : 16'd0,
                          status: refused, last: 1'b1};
            state <= S_WAIT;
          end
        end
        S_WAIT: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  `DTT_ASSERT(a_no_take_busy, !(in_xfer && state != S_IDLE), "item taken while busy")
  `DTT_ASSERT_NEXT(a_exec_scans, state == S_EXEC, state == S_SCAN, "exec not followed by scan")
  `DTT_ASSERT(a_free_due, !cmd.free_best || (stat.best_found && stat.best_due),
              "freeing an entry that is not due")
endmodule
`default_nettype wire

@@ test/tb.sv @@
// self-checking bench for the deadline timer table with a built-in timeout model
`default_nettype none
module tb;
  import dtt_pkg::*;

  localparam int NumEntries = 32;
  localparam int RandItems = 500;
  localparam int CycleLimit = 1500000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic in_taken = 1'b0;

  deadline_timer_table_core i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // timer table shadow
  logic [31:0] clk_ms;
  logic [31:0] slot_deadline [NumEntries];
  logic [15:0] slot_conn [NumEntries];
  logic        slot_held [NumEntries];
  logic        slot_dead [NumEntries];
  logic        slot_newest [NumEntries];

  in_item_t  pending_actions [$];
  out_item_t expected_results [$];
  int errors = 0;
  int cycles = 0;
  int actions_sent = 0;
  int reports_seen = 0;
  int results_seen = 0;

  function automatic int earliest_slot();
    int best;
    logic signed [31:0] best_left, left;
    best = -1;
    best_left = 0;
    for (int i = 0; i < NumEntries; i++) begin
      if (slot_held[i] && !slot_dead[i]) begin
        left = slot_deadline[i] - clk_ms;
        if (best < 0 || left < best_left) begin
          best = i;
          best_left = left;
        end
      end
    end
    return best;
  endfunction

  task automatic predict_action(input in_item_t it);
    int slot, e;
    logic refused;
    logic signed [31:0] left;
    out_item_t r;
    refused = 1'b0;
    case (action_t'(it.action))
      ACT_TICK: clk_ms = clk_ms + 1;
      ACT_ADD: begin
        slot = -1;
        for (int i = 0; i < NumEntries; i++)
          if (slot < 0 && !slot_held[i]) slot = i;
        if (slot < 0) begin
          refused = 1'b1;
        end else begin
          for (int i = 0; i < NumEntries; i++)
            if (slot_held[i] && slot_conn[i] == it.conn_id) slot_newest[i] = 1'b0;
          slot_deadline[slot] = clk_ms + 32'(it.delay_ms);
          slot_conn[slot] = it.conn_id;
          slot_held[slot] = 1'b1;
          slot_dead[slot] = 1'b0;
          slot_newest[slot] = 1'b1;
        end
      end
      ACT_DELETE: begin
        slot = -1;
        for (int i = 0; i < NumEntries; i++)
          if (slot < 0 && slot_held[i] && slot_newest[i] && slot_conn[i] == it.conn_id)
            slot = i;
        if (slot >= 0) slot_dead[slot] = 1'b1;
      end
      default: begin
        forever begin
          e = earliest_slot();
          if (e < 0) break;
          left = slot_deadline[e] - clk_ms;
          if (left > 0) break;
          r = '0;
          r.kind = 1'b1;
          r.expired_conn = slot_conn[e];
          expected_results.push_back(r);
          slot_held[e] = 1'b0;
          slot_dead[e] = 1'b0;
          slot_newest[e] = 1'b0;
        end
      end
    endcase
    for (int i = 0; i < NumEntries; i++)
      if (slot_held[i] && slot_dead[i]) begin
        slot_held[i] = 1'b0;
        slot_dead[i] = 1'b0;
        slot_newest[i] = 1'b0;
      end
    r = '0;
    r.status = refused;
    r.last = 1'b1;
    e = earliest_slot();
    if (e >= 0) begin
      left = slot_deadline[e] - clk_ms;
      r.have_next = 1'b1;
      if (left < 0) r.next_remaining_ms = 16'd0;
      else if (left > 65535) r.next_remaining_ms = 16'hffff;
      else r.next_remaining_ms = left[15:0];
    end
    expected_results.push_back(r);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch on result %0d: %s got %0h expected %0h", results_seen, what, got, want);
    errors++;
  endtask

  function automatic in_item_t make_item(input action_t a, input int c, input int d);
    in_item_t it;
    it.action = a;
    it.conn_id = 16'(c);
    it.delay_ms = 16'(d);
    return it;
  endfunction

  // input transfer seen at the rising edge
  always @(posedge clk) begin
    in_taken <= !rst && in_valid && !in_stall;
  end

  // driver: one transfer per item with a random gap before it
  int send_gap = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (in_taken) begin
        // accepted at the last rising edge
        predict_action(in_data);
        actions_sent++;
        send_gap = $urandom_range(0, 17);
        if ($urandom_range(0, 3) == 0) send_gap = 0;
        if (send_gap == 0 && pending_actions.size() > 0) begin
          in_data <= pending_actions.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end else if (!in_valid) begin
        if (send_gap > 0) send_gap--;
        else if (pending_actions.size() > 0) begin
          in_data <= pending_actions.pop_front();
          in_valid <= 1'b1;
        end
      end
    end
  end

  // receiver stall drawn per result
  int stall_left = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    out_item_t want;
    cycles++;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (out_data.kind) reports_seen++;
      stall_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 17);
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", out_data.kind, 0);
      end else begin
        want = expected_results.pop_front();
        if (out_data.kind !== want.kind) report_mismatch("kind", out_data.kind, want.kind);
        if (out_data.expired_conn !== want.expired_conn)
          report_mismatch("expired_conn", out_data.expired_conn, want.expired_conn);
        if (out_data.have_next !== want.have_next)
          report_mismatch("have_next", out_data.have_next, want.have_next);
        if (out_data.next_remaining_ms !== want.next_remaining_ms)
          report_mismatch("next_remaining_ms", out_data.next_remaining_ms,
                          want.next_remaining_ms);
        if (out_data.status !== want.status) report_mismatch("status", out_data.status, want.status);
        if (out_data.last !== want.last) report_mismatch("last", out_data.last, want.last);
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int a, c, d, ticks;
    clk_ms = '0;
    for (int i = 0; i < NumEntries; i++) begin
      slot_deadline[i] = '0;
      slot_conn[i] = '0;
      slot_held[i] = 1'b0;
      slot_dead[i] = 1'b0;
      slot_newest[i] = 1'b0;
    end
    // directed: empty expire, extremes, overwrite of newest, full table
    pending_actions.push_back(make_item(ACT_EXPIRE, 0, 0));
    pending_actions.push_back(make_item(ACT_ADD, 16'hffff, 16'hffff));
    pending_actions.push_back(make_item(ACT_ADD, 0, 0));
    pending_actions.push_back(make_item(ACT_ADD, 7, 2));
    pending_actions.push_back(make_item(ACT_ADD, 7, 1));
    pending_actions.push_back(make_item(ACT_DELETE, 7, 0));
    pending_actions.push_back(make_item(ACT_DELETE, 7, 0));
    pending_actions.push_back(make_item(ACT_DELETE, 1234, 16'hffff));
    pending_actions.push_back(make_item(ACT_TICK, 16'hffff, 16'hffff));
    pending_actions.push_back(make_item(ACT_EXPIRE, 0, 0));
    pending_actions.push_back(make_item(ACT_TICK, 0, 0));
    pending_actions.push_back(make_item(ACT_TICK, 0, 0));
    pending_actions.push_back(make_item(ACT_EXPIRE, 0, 0));
    for (int i = 0; i < 34; i++)
      pending_actions.push_back(make_item(ACT_ADD, i + 100, (i == 33) ? 16'hffff : 3 * i));
    pending_actions.push_back(make_item(ACT_DELETE, 16'hffff, 0));
    // random: short delays and a small set of connections so adds, deletes and expiries meet
    for (int i = 0; i < RandItems; i++) begin
      a = $urandom_range(0, 9);
      c = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 15);
      d = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 20);
      if (a < 4) pending_actions.push_back(make_item(ACT_TICK, c, d));
      else if (a < 7) pending_actions.push_back(make_item(ACT_ADD, c, d));
      else if (a < 8) pending_actions.push_back(make_item(ACT_DELETE, c, d));
      else pending_actions.push_back(make_item(ACT_EXPIRE, c, d));
    end
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    wait (pending_actions.size() == 0 && in_valid == 1'b0 && actions_sent > 0);
    wait (expected_results.size() == 0);
    repeat (200) @(posedge clk);
    $display("sent %0d actions, checked %0d results including %0d expiry reports",
             actions_sent, results_seen, reports_seen);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
